>>> src/swk_pkg.sv
// Shared types, constants and the arctangent table for the swerve kinematics block.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package swk_pkg;

  localparam int ANGLE_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TABLE_LEN        = 24;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // register indexes
  localparam logic [2:0] REG_VEL_GAIN  = 3'd0;
  localparam logic [2:0] REG_DEADBAND  = 3'd1;
  localparam logic [2:0] REG_HALF_LEN  = 3'd2;
  localparam logic [2:0] REG_HALF_WID  = 3'd3;
  localparam logic [2:0] REG_TICKS     = 3'd4;
  localparam logic [2:0] REG_SPD_GAIN  = 3'd5;

  // wheel order
  localparam logic [1:0] WHEEL_FR = 2'd0;
  localparam logic [1:0] WHEEL_FL = 2'd1;
  localparam logic [1:0] WHEEL_BL = 2'd2;
  localparam logic [1:0] WHEEL_BR = 2'd3;

  localparam logic [17:0] PI_Q16       = 18'd205887;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

  localparam int VEC_W = 23;   // wheel vector components, Q.8
  localparam int XY_W  = 35;   // CORDIC x/y, Q.16 plus growth

  typedef struct packed {
    logic       ld_in;
    logic       mul1;
    logic       mul2;
    logic       sums;
    logic       init;
    logic       iter;
    logic       mag;
    logic       spd;
    logic       tick;
    logic       ld_out;
    logic [1:0] wheel;
  } swk_cmd_t;

  typedef logic [31:0] atan_tbl_t [TABLE_LEN];

  localparam atan_tbl_t ATAN_TURNS32 = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // table entry rounded to angle_bits of a turn
  function automatic logic [31:0] atan_angle(input logic [4:0] idx, input int angle_bits);
    logic [32:0] s;
    s = {1'b0, ATAN_TURNS32[idx]} + (33'd1 << (31 - angle_bits));
    return s[31:0] >> (32 - angle_bits);
  endfunction

endpackage
`default_nettype wire

>>> src/swk_ctrl.sv
// Controller for the swerve kinematics block: sequences input capture, the
// shared CORDIC over the four wheels and the result handoff. Uses swk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module swk_ctrl #(
  parameter int CORDIC_STEPS = swk_pkg::CORDIC_STEPS_DEF,
  parameter int STEP_W       = $clog2(CORDIC_STEPS)
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire                   out_ready,
  output swk_pkg::swk_cmd_t     cmd,
  output logic [STEP_W-1:0]     step_idx
);
  import swk_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_SUMS, ST_INIT, ST_ITER, ST_MAG, ST_SPD, ST_TICK, ST_DONE
  } state_t;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [1:0]        wheel_r, wheel_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign step_idx  = step_r;

  always_comb begin
    cmd           = '0;
    cmd.wheel     = wheel_r;
    state_nxt     = state_r;
    step_nxt      = step_r;
    wheel_nxt     = wheel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_SUMS;
      end
      ST_SUMS: begin
        cmd.sums  = 1'b1;
        wheel_nxt = WHEEL_FR;
        state_nxt = ST_INIT;
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        step_nxt  = '0;
        state_nxt = ST_ITER;
      end
      ST_ITER: begin
        cmd.iter = 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_MAG;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_MAG: begin
        cmd.mag   = 1'b1;
        state_nxt = ST_SPD;
      end
      ST_SPD: begin
        cmd.spd   = 1'b1;
        state_nxt = ST_TICK;
      end
      ST_TICK: begin
        cmd.tick = 1'b1;
        if (wheel_r == WHEEL_BR) begin
          state_nxt = ST_DONE;
        end else begin
          wheel_nxt = wheel_r + 1'b1;
          state_nxt = ST_INIT;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.ld_out    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      wheel_r     <= WHEEL_FR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      wheel_r     <= wheel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> (!out_valid_r || out_ready))
    else $error("result register loaded while a transaction is pending");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while busy");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ITER) |-> (step_r <= LAST_STEP))
    else $error("CORDIC step out of range");

  a_wheel_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> $past(cmd.tick && (wheel_r == WHEEL_BR)) || $past(state_r == ST_DONE))
    else $error("result loaded before all wheels finished");

endmodule
`default_nettype wire

>>> src/swk_dp.sv
// Datapath for the swerve kinematics block: body velocity, wheel vectors,
// shared vectoring CORDIC, speed scaling, angle unwrap and tick conversion. Uses swk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module swk_dp #(
  parameter int ANGLE_BITS = swk_pkg::ANGLE_BITS_DEF,
  parameter int STEP_W     = 4
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  swk_pkg::swk_cmd_t        cmd,
  input  wire [STEP_W-1:0]         step_idx,
  input  wire signed [15:0]        joy_x,
  input  wire signed [15:0]        joy_y,
  input  wire signed [15:0]        turn_x,
  input  wire [9:0]                velocity_gain,
  input  wire [15:0]               deadband_threshold,
  input  wire [15:0]               half_length,
  input  wire [15:0]               half_width,
  input  wire [20:0]               ticks_per_turn,
  input  wire [9:0]                speed_out_gain,
  output logic [15:0]              fr_speed,
  output logic signed [31:0]       fr_angle,
  output logic [15:0]              fl_speed,
  output logic signed [31:0]       fl_angle,
  output logic [15:0]              bl_speed,
  output logic signed [31:0]       bl_angle,
  output logic [15:0]              br_speed,
  output logic signed [31:0]       br_angle
);
  import swk_pkg::*;

  localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

  logic signed [15:0] jx_r, jy_r, tx_r;
  logic signed [27:0] pvx_r, pvy_r;
  logic signed [32:0] pl_r, pw_r;
  logic signed [21:0] vx_r, vy_r, wl_r, ww_r;
  logic signed [VEC_W-1:0] a_r, b_r, c_r, d_r;
  logic signed [XY_W-1:0] x_r, y_r;
  logic [ANGLE_BITS-1:0]  z_r;
  logic                   zero_r;
  logic signed [35:0]     mag_r;
  logic signed [31:0]     wa_r [4];
  logic [15:0]            stg_spd_r [4];
  logic signed [31:0]     stg_ang_r [4];

  // velocity and yaw terms
  logic signed [27:0] pvx, pvy, rvx, rvy;
  logic signed [32:0] pl, pw;
  logic signed [51:0] wlp, wwp, wlr, wwr;
  logic signed [21:0] vxs, vys, vxa, vya;

  always_comb begin
    pvx = jx_r * $signed({1'b0, velocity_gain});
    pvy = -(jy_r * $signed({1'b0, velocity_gain}));
    pl  = tx_r * $signed({1'b0, half_length});
    pw  = tx_r * $signed({1'b0, half_width});
    wlp = pl_r * $signed({1'b0, PI_Q16});
    wwp = pw_r * $signed({1'b0, PI_Q16});
    wlr = (wlp + (52'sd1 <<< 30)) >>> 31;
    wwr = (wwp + (52'sd1 <<< 30)) >>> 31;
    rvx = (pvx_r + 28'sd64) >>> 7;
    rvy = (pvy_r + 28'sd64) >>> 7;
    vxs = rvx[21:0];
    vys = rvy[21:0];
    vxa = (vxs < 0) ? -vxs : vxs;
    vya = (vys < 0) ? -vys : vys;
  end

  // wheel operand pick: heading is atan2(ysel, xsel)
  logic signed [VEC_W-1:0] ysel, xsel;
  logic signed [XY_W-1:0]  x0, y0;

  always_comb begin
    case (cmd.wheel)
      WHEEL_FR: begin ysel = b_r; xsel = c_r; end
      WHEEL_FL: begin ysel = b_r; xsel = d_r; end
      WHEEL_BL: begin ysel = a_r; xsel = d_r; end
      default:  begin ysel = a_r; xsel = c_r; end
    endcase
    x0 = XY_W'(xsel) <<< 8;
    y0 = XY_W'(ysel) <<< 8;
  end

  // one CORDIC micro-rotation
  logic signed [XY_W-1:0] dx, dy;
  logic [ANGLE_BITS-1:0]  step_ang;

  always_comb begin
    dx       = y_r >>> step_idx;
    dy       = x_r >>> step_idx;
    step_ang = ANGLE_BITS'(atan_angle(5'(step_idx), ANGLE_BITS));
  end

  // speed, unwrap, ticks
  logic signed [65:0]     magp, magr;
  logic signed [46:0]     sp, spr;
  logic [15:0]            spd;
  logic [ANGLE_BITS-1:0]  ang, dlt;
  logic signed [31:0]     wa_cur, wstep, wa_new;
  logic signed [53:0]     tp, tpr;
  logic signed [31:0]     ticks;

  always_comb begin
    magp = x_r * $signed({1'b0, INV_GAIN_Q30});
    magr = (magp + (66'sd1 <<< 29)) >>> 30;
    sp   = mag_r * $signed({1'b0, speed_out_gain});
    spr  = (sp + 47'sd32768) >>> 16;
    if (spr > 47'sd65535) begin
      spd = 16'hFFFF;
    end else if (spr < 0) begin
      spd = 16'd0;
    end else begin
      spd = spr[15:0];
    end
    wa_cur = wa_r[cmd.wheel];
    ang    = zero_r ? '0 : z_r;
    dlt    = ang - wa_cur[ANGLE_BITS-1:0];
    wstep  = (dlt > HALF_TURN) ? (32'(dlt) - (32'sd1 <<< ANGLE_BITS)) : 32'(dlt);
    wa_new = wa_cur + wstep;
    tp     = wa_cur * $signed({1'b0, ticks_per_turn});
    tpr    = (tp + (54'sd1 <<< (ANGLE_BITS - 1))) >>> ANGLE_BITS;
    if (tpr > 54'sd2147483647) begin
      ticks = 32'sh7FFFFFFF;
    end else if (tpr < -54'sd2147483648) begin
      ticks = 32'sh80000000;
    end else begin
      ticks = tpr[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        wa_r[i] <= '0;
      end
    end else if (cmd.spd) begin
      wa_r[cmd.wheel] <= wa_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      jx_r <= joy_x;
      jy_r <= joy_y;
      tx_r <= turn_x;
    end
    if (cmd.mul1) begin
      pvx_r <= pvx;
      pvy_r <= pvy;
      pl_r  <= pl;
      pw_r  <= pw;
    end
    if (cmd.mul2) begin
      vx_r <= ($unsigned(vxa) < {6'd0, deadband_threshold}) ? '0 : vxs;
      vy_r <= ($unsigned(vya) < {6'd0, deadband_threshold}) ? '0 : vys;
      wl_r <= wlr[21:0];
      ww_r <= wwr[21:0];
    end
    if (cmd.sums) begin
      a_r <= VEC_W'(vx_r) - VEC_W'(wl_r);
      b_r <= VEC_W'(vx_r) + VEC_W'(wl_r);
      c_r <= VEC_W'(vy_r) - VEC_W'(ww_r);
      d_r <= VEC_W'(vy_r) + VEC_W'(ww_r);
    end
    if (cmd.init) begin
      zero_r <= (xsel == 0) && (ysel == 0);
      if (x0 < 0) begin
        x_r <= -x0;
        y_r <= -y0;
        z_r <= HALF_TURN;
      end else begin
        x_r <= x0;
        y_r <= y0;
        z_r <= '0;
      end
    end
    if (cmd.iter) begin
      if (y_r >= 0) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + step_ang;
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - step_ang;
      end
    end
    if (cmd.mag) begin
      mag_r <= zero_r ? '0 : magr[35:0];
    end
    if (cmd.spd) begin
      stg_spd_r[cmd.wheel] <= spd;
    end
    if (cmd.tick) begin
      stg_ang_r[cmd.wheel] <= ticks;
    end
    if (cmd.ld_out) begin
      fr_speed <= stg_spd_r[WHEEL_FR];
      fr_angle <= stg_ang_r[WHEEL_FR];
      fl_speed <= stg_spd_r[WHEEL_FL];
      fl_angle <= stg_ang_r[WHEEL_FL];
      bl_speed <= stg_spd_r[WHEEL_BL];
      bl_angle <= stg_ang_r[WHEEL_BL];
      br_speed <= stg_spd_r[WHEEL_BR];
      br_angle <= stg_ang_r[WHEEL_BR];
    end
  end

endmodule
`default_nettype wire

>>> src/swerve_wheel_kinematics_unwrap.sv
// Top level of the swerve kinematics block: configuration registers, controller
// and datapath. Depends on swk_pkg, swk_ctrl and swk_dp.
//
//   channel  | handshake          | payload
//   input    | in_valid/in_ready  | in_joy_x, in_joy_y, in_turn_x
//   result   | out_valid/out_ready| out_{fr,fl,bl,br}_{speed,angle}
//   config   | psel/penable/pwrite| paddr, pwdata, prdata (pready tied high)
//
// Processing time is set by the single CORDIC unit shared by the four wheels,
// one micro-rotation per cycle; a new transaction is accepted only once the previous
// one has loaded its result and returned to idle.
// in_ready is high only while idle; a finished result sits in the output register
// and the next transaction may run meanwhile, holding only at its final handoff.
// Synchronous reset clears control state and stored wheel angles, presets config registers.
`timescale 1ns / 1ps
`default_nettype none
module swerve_wheel_kinematics_unwrap #(
  parameter int ANGLE_BITS   = swk_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = swk_pkg::CORDIC_STEPS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire signed [15:0]                in_joy_x,
  input  wire signed [15:0]                in_joy_y,
  input  wire signed [15:0]                in_turn_x,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [15:0]                      out_fr_speed,
  output logic signed [31:0]               out_fr_angle,
  output logic [15:0]                      out_fl_speed,
  output logic signed [31:0]               out_fl_angle,
  output logic [15:0]                      out_bl_speed,
  output logic signed [31:0]               out_bl_angle,
  output logic [15:0]                      out_br_speed,
  output logic signed [31:0]               out_br_angle,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [swk_pkg::PADDR_W-1:0]       paddr,
  input  wire [swk_pkg::PDATA_W-1:0]       pwdata,
  output logic [swk_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);
  import swk_pkg::*;

  localparam int STEP_W = $clog2(CORDIC_STEPS);

  logic [9:0]  vel_gain_r;
  logic [15:0] deadband_r;
  logic [15:0] half_len_r;
  logic [15:0] half_wid_r;
  logic [20:0] ticks_r;
  logic [9:0]  spd_gain_r;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_gain_r <= 10'd100;
      deadband_r <= 16'd13;
      half_len_r <= 16'd9428;
      half_wid_r <= 16'd9428;
      ticks_r    <= 21'd2048;
      spd_gain_r <= 10'd100;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_VEL_GAIN: vel_gain_r <= pwdata[9:0];
        REG_DEADBAND: deadband_r <= pwdata[15:0];
        REG_HALF_LEN: half_len_r <= pwdata[15:0];
        REG_HALF_WID: half_wid_r <= pwdata[15:0];
        REG_TICKS:    ticks_r    <= pwdata[20:0];
        REG_SPD_GAIN: spd_gain_r <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_VEL_GAIN: prdata = {22'd0, vel_gain_r};
      REG_DEADBAND: prdata = {16'd0, deadband_r};
      REG_HALF_LEN: prdata = {16'd0, half_len_r};
      REG_HALF_WID: prdata = {16'd0, half_wid_r};
      REG_TICKS:    prdata = {11'd0, ticks_r};
      REG_SPD_GAIN: prdata = {22'd0, spd_gain_r};
      default:      prdata = '0;
    endcase
  end

  swk_cmd_t          cmd;
  logic [STEP_W-1:0] step_idx;

  swk_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .STEP_W      (STEP_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .step_idx (step_idx)
  );

  swk_dp #(
    .ANGLE_BITS(ANGLE_BITS),
    .STEP_W    (STEP_W)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .step_idx          (step_idx),
    .joy_x             (in_joy_x),
    .joy_y             (in_joy_y),
    .turn_x            (in_turn_x),
    .velocity_gain     (vel_gain_r),
    .deadband_threshold(deadband_r),
    .half_length       (half_len_r),
    .half_width        (half_wid_r),
    .ticks_per_turn    (ticks_r),
    .speed_out_gain    (spd_gain_r),
    .fr_speed          (out_fr_speed),
    .fr_angle          (out_fr_angle),
    .fl_speed          (out_fl_speed),
    .fl_angle          (out_fl_angle),
    .bl_speed          (out_bl_speed),
    .bl_angle          (out_bl_angle),
    .br_speed          (out_br_speed),
    .br_angle          (out_br_angle)
  );

endmodule
`default_nettype wire

>>> bench/swerve_wheel_kinematics_unwrap_tb.sv
// Self-checking bench for the swerve kinematics block: directed and random stick
// commands, APB register sweeps, random stalls. Depends on swk_pkg and the block.
`timescale 1ns / 1ps
module swerve_wheel_kinematics_unwrap_tb;
  import swk_pkg::*;

  localparam int AB = 16;
  localparam int STEPS = 16;
  localparam int WDOG_LIMIT = 20000;

  typedef struct {
    logic signed [15:0] jx, jy, tx;
  } stick_t;

  typedef struct {
    logic [15:0] spd[4];
    logic signed [31:0] ang[4];
  } wheel_cmd_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [15:0] in_joy_x, in_joy_y, in_turn_x;
  logic [15:0] out_fr_speed, out_fl_speed, out_bl_speed, out_br_speed;
  logic signed [31:0] out_fr_angle, out_fl_angle, out_bl_angle, out_br_angle;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  swerve_wheel_kinematics_unwrap u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_joy_x(in_joy_x), .in_joy_y(in_joy_y), .in_turn_x(in_turn_x),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_fr_speed(out_fr_speed), .out_fr_angle(out_fr_angle),
    .out_fl_speed(out_fl_speed), .out_fl_angle(out_fl_angle),
    .out_bl_speed(out_bl_speed), .out_bl_angle(out_bl_angle),
    .out_br_speed(out_br_speed), .out_br_angle(out_br_angle),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor copy of registers and wheel state
  longint vel_gain, db_thresh, half_len, half_wid, ticks_turn, spd_gain;
  logic [31:0] steer_acc[4];

  stick_t stick_q[$];
  wheel_cmd_t cmd_q[$];
  int errors, n_sent, n_rcvd, idle_cnt;
  bit no_idle, hold_rx;
  int hold_cnt;

  function automatic longint asr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint rnd(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint dead_zone(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    return (m < db_thresh) ? 0 : v;
  endfunction

  function automatic void wheel_solve(input int w, input longint yv, input longint xv,
                                      inout wheel_cmd_t r);
    longint x, y, dx, dy, mag, spd, sa, tk;
    logic [31:0] z, a, d, msk, half;
    msk = (32'd1 << AB) - 1;
    half = 32'd1 << (AB - 1);
    x = xv * 256; y = yv * 256; z = 0;
    if (xv == 0 && yv == 0) begin
      mag = 0;
    end else begin
      if (x < 0) begin
        x = -x; y = -y; z = half;
      end
      for (int i = 0; i < STEPS && i < TABLE_LEN; i++) begin
        a = (ATAN_TURNS32[i] + (32'd1 << (31 - AB))) >> (32 - AB);
        dx = asr(y, i); dy = asr(x, i);
        if (y >= 0) begin
          x += dx; y -= dy; z += a;
        end else begin
          x -= dx; y += dy; z -= a;
        end
      end
      mag = rnd(x * longint'(INV_GAIN_Q30), 30);
    end
    z = z & msk;
    spd = rnd(mag * spd_gain, 16);
    if (spd > 65535) spd = 65535;
    if (spd < 0) spd = 0;
    d = (z - steer_acc[w]) & msk;
    if (d > half) steer_acc[w] = steer_acc[w] - ((32'd1 << AB) - d);
    else steer_acc[w] = steer_acc[w] + d;
    sa = longint'($signed(steer_acc[w]));
    tk = rnd(sa * ticks_turn, AB);
    if (tk > 64'sd2147483647) tk = 64'sd2147483647;
    if (tk < -64'sd2147483648) tk = -64'sd2147483648;
    r.spd[w] = spd[15:0];
    r.ang[w] = tk[31:0];
  endfunction

  function automatic wheel_cmd_t predict_wheels(stick_t s);
    wheel_cmd_t r;
    longint vx, vy, wl, ww, a, b, c, d;
    vx = dead_zone(rnd(longint'(s.jx) * vel_gain, 7));
    vy = dead_zone(rnd(-longint'(s.jy) * vel_gain, 7));
    wl = rnd(longint'(s.tx) * half_len * longint'(PI_Q16), 31);
    ww = rnd(longint'(s.tx) * half_wid * longint'(PI_Q16), 31);
    a = vx - wl; b = vx + wl; c = vy - ww; d = vy + ww;
    wheel_solve(WHEEL_FR, b, c, r);
    wheel_solve(WHEEL_FL, b, d, r);
    wheel_solve(WHEEL_BL, a, d, r);
    wheel_solve(WHEEL_BR, a, c, r);
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        cmd_q.push_back(predict_wheels('{in_joy_x, in_joy_y, in_turn_x}));
        n_sent++;
      end
      if (stick_q.size() > 0 && (no_idle || $urandom_range(99) >= 22)) begin
        stick_t s;
        s = stick_q.pop_front();
        in_valid <= 1;
        in_joy_x <= s.jx; in_joy_y <= s.jy; in_turn_x <= s.tx;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        wheel_cmd_t e;
        logic [15:0] gs[4];
        logic signed [31:0] ga[4];
        gs = '{out_fr_speed, out_fl_speed, out_bl_speed, out_br_speed};
        ga = '{out_fr_angle, out_fl_angle, out_bl_angle, out_br_angle};
        n_rcvd++;
        if (cmd_q.size() == 0) begin
          $display("%0t: unexpected result transaction", $time);
          errors++;
        end else begin
          e = cmd_q.pop_front();
          for (int w = 0; w < 4; w++) begin
            if (gs[w] !== e.spd[w]) begin
              $display("%0t: wheel %0d speed exp %0d got %0d", $time, w, e.spd[w], gs[w]);
              errors++;
            end
            if (ga[w] !== e.ang[w]) begin
              $display("%0t: wheel %0d angle exp %0d got %0d", $time, w, e.ang[w], ga[w]);
              errors++;
            end
          end
        end
      end
      if (hold_rx && hold_cnt < 600) begin
        hold_cnt <= hold_cnt + 1;
        out_ready <= 0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= 22);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cnt <= 0;
    end else if (stick_q.size() > 0 || cmd_q.size() > 0 || in_valid) begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt > WDOG_LIMIT) begin
        $display("swerve_wheel_kinematics_unwrap_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= PADDR_W'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_VEL_GAIN: vel_gain = val & 32'h3FF;
      REG_DEADBAND: db_thresh = val & 32'hFFFF;
      REG_HALF_LEN: half_len = val & 32'hFFFF;
      REG_HALF_WID: half_wid = val & 32'hFFFF;
      REG_TICKS:    ticks_turn = val & 32'h1FFFFF;
      REG_SPD_GAIN: spd_gain = val & 32'h3FF;
      default: ;
    endcase
  endtask

  task automatic drain_all();
    while (stick_q.size() > 0 || in_valid || cmd_q.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) stick_q.push_back('{rand_axis(), rand_axis(), rand_axis()});
  endtask

  initial begin
    rst_n = 0; in_valid = 0; out_ready = 0;
    in_joy_x = 0; in_joy_y = 0; in_turn_x = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    errors = 0; n_sent = 0; n_rcvd = 0; idle_cnt = 0;
    no_idle = 0; hold_rx = 0; hold_cnt = 0;
    vel_gain = 100; db_thresh = 13; half_len = 9428; half_wid = 9428;
    ticks_turn = 2048; spd_gain = 100;
    for (int w = 0; w < 4; w++) steer_acc[w] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // directed: extremes, zero vector, deadband edge, half-turn steps
    stick_q.push_back('{16'sd0, 16'sd0, 16'sd0});
    stick_q.push_back('{16'sh7FFF, 16'sd0, 16'sd0});
    stick_q.push_back('{16'sh8000, 16'sd0, 16'sd0});
    stick_q.push_back('{16'sh7FFF, 16'sd0, 16'sd0});
    stick_q.push_back('{16'sd0, 16'sh7FFF, 16'sd0});
    stick_q.push_back('{16'sd0, 16'sh8000, 16'sd0});
    stick_q.push_back('{16'sd0, 16'sd0, 16'sh7FFF});
    stick_q.push_back('{16'sd0, 16'sd0, 16'sh8000});
    stick_q.push_back('{16'sh7FFF, 16'sh8000, 16'sh7FFF});
    stick_q.push_back('{16'sh8000, 16'sh7FFF, 16'sh8000});
    stick_q.push_back('{16'sd16, 16'sd0, 16'sd0});
    stick_q.push_back('{16'sd17, -16'sd17, 16'sd0});
    stick_q.push_back('{-16'sd16, 16'sd16, 16'sd1});
    stick_q.push_back('{16'sh5555, 16'shAAAA, 16'sh1234});
    drain_all();

    // register sweep with extremes
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          reg_write(REG_VEL_GAIN, 1000); reg_write(REG_DEADBAND, 0);
          reg_write(REG_HALF_LEN, 65535); reg_write(REG_HALF_WID, 0);
          reg_write(REG_TICKS, 1048576); reg_write(REG_SPD_GAIN, 1000);
        end
        1: begin
          reg_write(REG_VEL_GAIN, 1); reg_write(REG_DEADBAND, 65535);
          reg_write(REG_HALF_LEN, 0); reg_write(REG_HALF_WID, 65535);
          reg_write(REG_TICKS, 1); reg_write(REG_SPD_GAIN, 1);
        end
        default: begin
          reg_write(REG_VEL_GAIN, $urandom_range(1000, 1));
          reg_write(REG_DEADBAND, $urandom_range(3) == 0 ? $urandom : $urandom_range(400));
          reg_write(REG_HALF_LEN, $urandom);
          reg_write(REG_HALF_WID, $urandom);
          reg_write(REG_TICKS, $urandom_range(1048576, 1));
          reg_write(REG_SPD_GAIN, $urandom_range(1000, 1));
        end
      endcase
      if (phase == 3) no_idle = 1;
      if (phase == 4) begin
        no_idle = 0; hold_rx = 1;
      end
      queue_random(phase < 2 ? 60 : 170);
      drain_all();
    end

    if (errors == 0) begin
      $display("Covered %0d stick transactions over six register settings with stalls.",
               n_sent);
      $display("swerve_wheel_kinematics_unwrap_tb: PASS");
    end else begin
      $display("%0d mismatches in %0d results", errors, n_rcvd);
      $display("swerve_wheel_kinematics_unwrap_tb: FAIL");
    end
    $finish;
  end
endmodule

>>> sim.f
src/swk_pkg.sv
src/swk_ctrl.sv
src/swk_dp.sv
src/swerve_wheel_kinematics_unwrap.sv
bench/swerve_wheel_kinematics_unwrap_tb.sv
